FILE: rtl/core/mmbd_pkg.sv
// shared types and constants for the min/max bucket decimator
package mmbd_pkg;
	localparam int unsigned SAMPLE_W = 64;
	localparam int unsigned CFG_W = 21;
	localparam logic [SAMPLE_W-1:0] GAP_BITS = 64'h7FF8_0000_0000_0000;
	localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_bits;
		logic                end_of_data;
	} in_beat_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] first_value;
		logic [SAMPLE_W-1:0] second_value;
		logic                is_gap;
	} out_beat_t;

	// a < b for finite binary64 patterns, -0 equal to +0
	function automatic logic f64_less(input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b);
		logic a_zero;
		logic b_zero;
		logic res;
		a_zero = (a[62:0] == 63'd0);
		b_zero = (b[62:0] == 63'd0);
		if (a_zero && b_zero) begin
			res = 1'b0;
		end else if (a[63] != b[63]) begin
			res = a[63];
		end else if (a[63]) begin
			res = (a[62:0] > b[62:0]);
		end else begin
			res = (a[62:0] < b[62:0]);
		end
		return res;
	endfunction
endpackage

FILE: rtl/core/mmbd_if.sv
// valid/ready channel carrying one payload beat
interface mmbd_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/minmax_bucket_decimator_core.sv
// min/max envelope decimator over binary64 sample beats
//  channel  | dir | payload
//  in_ch    | in  | sample_bits, end_of_data
//  out_ch   | out | first_value, second_value, is_gap
//  cfg      | in  | cfg_we, cfg_wdata (bucket_width)
// one sample beat per cycle unless a closing beat stalls; fold logic sits
// between the input register and the extreme registers, a closed bucket
// lands in the result register, once its closing beat leaves the input register
// a closing beat held in the input register behind a waiting result stalls input
// reset sets width 1 and clears the open bucket.
module minmax_bucket_decimator_core #(
	parameter int unsigned MAX_BUCKET_WIDTH = 1048576
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mmbd_pkg::CFG_W-1:0] cfg_wdata,
	mmbd_if.sink   in_ch,
	mmbd_if.source out_ch
);
	localparam int unsigned POS_W = $clog2(MAX_BUCKET_WIDTH + 1);
	localparam int unsigned WW = (POS_W > mmbd_pkg::CFG_W) ? POS_W : mmbd_pkg::CFG_W;

	logic [mmbd_pkg::CFG_W-1:0] width_q;
	logic [WW-1:0] eff_w;
	logic [WW-1:0] wide_w;

	logic valid_s1;
	mmbd_pkg::in_beat_t beat_s1;
	logic [POS_W-1:0] pos_q, lo_pos_q, hi_pos_q;
	logic [mmbd_pkg::SAMPLE_W-1:0] lo_q, hi_q;
	logic seen_q;
	logic out_valid_q;
	mmbd_pkg::out_beat_t out_q;

	logic fire_s1, take_in, finite;
	logic [POS_W-1:0] lo_pos_n, hi_pos_n;
	logic [mmbd_pkg::SAMPLE_W-1:0] lo_n, hi_n;
	logic seen_n, close;
	logic [WW-1:0] pos_inc;
	mmbd_pkg::out_beat_t res;

	assign wide_w = WW'(width_q);
	always_comb begin
		if (wide_w == '0) begin
			eff_w = WW'(1);
		end else if (wide_w > WW'(MAX_BUCKET_WIDTH)) begin
			eff_w = WW'(MAX_BUCKET_WIDTH);
		end else begin
			eff_w = wide_w;
		end
	end

	assign fire_s1 = valid_s1 && (!close || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || fire_s1;
	assign take_in = in_ch.valid && in_ch.ready;

	always_comb begin
		finite = (beat_s1.sample_bits[62:52] != mmbd_pkg::EXP_ALL_ONES);
		lo_n = lo_q;
		hi_n = hi_q;
		lo_pos_n = lo_pos_q;
		hi_pos_n = hi_pos_q;
		seen_n = seen_q;
		if (finite) begin
			if (!seen_q) begin
				lo_n = beat_s1.sample_bits;
				hi_n = beat_s1.sample_bits;
				lo_pos_n = pos_q;
				hi_pos_n = pos_q;
				seen_n = 1'b1;
			end else begin
				if (mmbd_pkg::f64_less(beat_s1.sample_bits, lo_q)) begin
					lo_n = beat_s1.sample_bits;
					lo_pos_n = pos_q;
				end
				if (mmbd_pkg::f64_less(hi_q, beat_s1.sample_bits)) begin
					hi_n = beat_s1.sample_bits;
					hi_pos_n = pos_q;
				end
			end
		end
		pos_inc = WW'(pos_q) + WW'(1);
		close = beat_s1.end_of_data || (pos_inc >= eff_w);
		if (!seen_n) begin
			res.first_value = mmbd_pkg::GAP_BITS;
			res.second_value = mmbd_pkg::GAP_BITS;
			res.is_gap = 1'b1;
		end else if (hi_pos_n < lo_pos_n) begin
			res.first_value = hi_n;
			res.second_value = lo_n;
			res.is_gap = 1'b0;
		end else begin
			res.first_value = lo_n;
			res.second_value = hi_n;
			res.is_gap = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= mmbd_pkg::CFG_W'(1);
			valid_s1 <= 1'b0;
			pos_q <= '0;
			seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				width_q <= cfg_wdata;
			end
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire_s1) begin
				if (close) begin
					pos_q <= '0;
					seen_q <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					pos_q <= pos_inc[POS_W-1:0];
					seen_q <= seen_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			beat_s1 <= in_ch.payload;
		end
		if (fire_s1) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
			lo_pos_q <= lo_pos_n;
			hi_pos_q <= hi_pos_n;
			if (close) begin
				out_q <= res;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;
endmodule

FILE: rtl/core/mmbd_checker.sv
// port-level checks for the decimator core, bound to the core module
module mmbd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input mmbd_pkg::out_beat_t out_payload
);
	a_gap_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.is_gap |->
		out_payload.first_value == mmbd_pkg::GAP_BITS &&
		out_payload.second_value == mmbd_pkg::GAP_BITS) else $error("gap beat not nan");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result beat dropped");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid})) else $error("handshake unknown");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input stalled with free result");
endmodule

bind minmax_bucket_decimator_core mmbd_checker u_mmbd_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
